// ===== rtl/lphs_pkg.sv =====
`timescale 1ns / 1ps
package lphs_pkg;

   localparam int LOG2_MAX_SLOTS = 10;
   localparam int SLOT_AW        = LOG2_MAX_SLOTS;
   localparam int SLOT_CAP       = 1 << LOG2_MAX_SLOTS;
   localparam int KEY_W          = 32;
   localparam int IDX_W          = 10;
   localparam int CFG_W          = 4;

   localparam logic [KEY_W-1:0] EMPTY_MARK = '1;
   localparam logic [CFG_W-1:0] CFG_RESET  = CFG_W'(10);

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_FULL     = 2'd1;
   localparam logic [1:0] STATUS_RESERVED = 2'd2;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_QUERY  = 2'd1,
      OP_REMOVE = 2'd2,
      OP_CLEAR  = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_SWEEP,
      ST_IDLE,
      ST_PROBE,
      ST_FINISH
   } state_type;

   typedef struct packed {
      op_type                  op;
      logic signed [KEY_W-1:0] key;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic             found;
      logic [IDX_W-1:0] slot_index;
   } rsp_type;

   typedef struct packed {
      logic               wr_en;
      logic [SLOT_AW-1:0] wr_addr;
      logic [KEY_W-1:0]   wr_data;
      logic               rd_en;
      logic [SLOT_AW-1:0] rd_addr;
   } mem_req_type;

endpackage

// ===== rtl/lphs_slot_ram.sv =====
`timescale 1ns / 1ps
module lphs_slot_ram (
   input  logic                       clock,
   input  lphs_pkg::mem_req_type      mem_req,
   output logic [lphs_pkg::KEY_W-1:0] rd_data
);
   import lphs_pkg::*;

   logic [KEY_W-1:0] mem [SLOT_CAP];
   logic [KEY_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr] <= mem_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lphs_ctrl.sv =====
`timescale 1ns / 1ps
module lphs_ctrl (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [lphs_pkg::CFG_W-1:0] table_log2,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  lphs_pkg::req_type          req_payload,
   input  logic                       out_busy,
   output logic                       done,
   output lphs_pkg::rsp_type          result,
   output lphs_pkg::mem_req_type      mem_req,
   input  logic [lphs_pkg::KEY_W-1:0] rd_data
);
   import lphs_pkg::*;

   state_type          state_ff, state_in;
   op_type             op_ff, op_in;
   logic [KEY_W-1:0]   key_ff, key_in;
   logic [SLOT_AW-1:0] pos_ff, pos_in;
   logic [SLOT_AW-1:0] chk_pos_ff, chk_pos_in;
   logic [SLOT_AW-1:0] chk_cnt_ff, chk_cnt_in;
   logic               chk_vld_ff, chk_vld_in;
   logic [SLOT_AW-1:0] sweep_ff, sweep_in;
   logic               sweep_rsp_ff, sweep_rsp_in;
   rsp_type            res_ff, res_in;

   logic [CFG_W-1:0]   act_log2;
   logic [SLOT_AW:0]   len_w;
   logic [SLOT_AW-1:0] mask;
   logic [SLOT_AW-1:0] home;
   logic [KEY_W-1:0]   target;
   logic               accept;

   always_comb begin
      act_log2 = (table_log2 > CFG_W'(LOG2_MAX_SLOTS)) ? CFG_W'(LOG2_MAX_SLOTS) : table_log2;
      len_w    = (SLOT_AW+1)'(1) << act_log2;
      mask     = SLOT_AW'(len_w - (SLOT_AW+1)'(1));
      home     = SLOT_AW'($unsigned(req_payload.key)) & mask;
      target   = (op_ff == OP_INSERT) ? EMPTY_MARK : key_ff;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign result    = res_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_SWEEP;
         sweep_ff     <= '0;
         sweep_rsp_ff <= 1'b0;
         chk_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         sweep_rsp_ff <= sweep_rsp_in;
         chk_vld_ff   <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      key_ff     <= key_in;
      pos_ff     <= pos_in;
      chk_pos_ff <= chk_pos_in;
      chk_cnt_ff <= chk_cnt_in;
      res_ff     <= res_in;
   end

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      key_in       = key_ff;
      pos_in       = pos_ff;
      chk_pos_in   = chk_pos_ff;
      chk_cnt_in   = chk_cnt_ff;
      chk_vld_in   = 1'b0;
      sweep_in     = sweep_ff;
      sweep_rsp_in = sweep_rsp_ff;
      res_in       = res_ff;
      done         = 1'b0;
      mem_req      = '0;

      case (state_ff)
         ST_SWEEP: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = sweep_ff;
            mem_req.wr_data = EMPTY_MARK;
            sweep_in        = sweep_ff + 1'b1;
            if (sweep_ff == SLOT_AW'(SLOT_CAP - 1)) begin
               state_in = sweep_rsp_ff ? ST_FINISH : ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               op_in      = req_payload.op;
               key_in     = $unsigned(req_payload.key);
               pos_in     = home;
               chk_cnt_in = '0;
               res_in     = '0;
               if (req_payload.op == OP_CLEAR) begin
                  sweep_in     = '0;
                  sweep_rsp_in = 1'b1;
                  state_in     = ST_SWEEP;
               end else if ($unsigned(req_payload.key) == EMPTY_MARK) begin
                  res_in.status = STATUS_RESERVED;
                  state_in      = ST_FINISH;
               end else begin
                  state_in = ST_PROBE;
               end
            end
         end
         ST_PROBE: begin
            // one read issued per cycle, checked when the data returns
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = pos_ff;
            pos_in          = (pos_ff + 1'b1) & mask;
            chk_pos_in      = pos_ff;
            chk_vld_in      = 1'b1;
            if (chk_vld_ff) begin
               chk_cnt_in = chk_cnt_ff + 1'b1;
               if (rd_data == target) begin
                  state_in   = ST_FINISH;
                  chk_vld_in = 1'b0;
                  case (op_ff)
                     OP_INSERT: begin
                        mem_req.wr_en     = 1'b1;
                        mem_req.wr_addr   = chk_pos_ff;
                        mem_req.wr_data   = key_ff;
                        res_in.slot_index = IDX_W'(chk_pos_ff);
                     end
                     OP_REMOVE: begin
                        mem_req.wr_en   = 1'b1;
                        mem_req.wr_addr = chk_pos_ff;
                        mem_req.wr_data = EMPTY_MARK;
                        res_in.found    = 1'b1;
                     end
                     default: begin
                        res_in.found = 1'b1;
                     end
                  endcase
               end else if (chk_cnt_ff == mask) begin
                  // every active slot looked at
                  state_in   = ST_FINISH;
                  chk_vld_in = 1'b0;
                  if (op_ff == OP_INSERT) begin
                     res_in.status = STATUS_FULL;
                  end
               end
            end
         end
         ST_FINISH: begin
            if (!out_busy) begin
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_no_write_on_accept: assert property (@(posedge clock) disable iff (reset)
      accept |-> !mem_req.wr_en)
      else $error("slot write while a request is taken");

   a_done_needs_room: assert property (@(posedge clock) disable iff (reset)
      done |-> !out_busy)
      else $error("result produced while the output register is held");

   a_reserved_key: assert property (@(posedge clock) disable iff (reset)
      (accept && req_payload.op != OP_CLEAR && $unsigned(req_payload.key) == EMPTY_MARK)
      |=> (state_ff == ST_FINISH && res_ff.status == STATUS_RESERVED))
      else $error("reserved key not refused");

   a_probe_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PROBE && chk_vld_ff) |-> (chk_cnt_ff <= mask))
      else $error("probe ran past the active table");

endmodule

// ===== rtl/linear_probe_hash_set.sv =====
`timescale 1ns / 1ps
// sequence: a reserved key goes from idle straight to the finish state; a probe examines k
// slots (1 to the active slot count, at most 1024), one slot read per cycle, each checked when
// its data returns; clear sweeps all 1024 slots, one slot written a cycle; every result waits
// in the finish state until the response register is free; requests are taken one at a time
// reset: synchronous, active high; a sweep then empties all 1024 slots, req_ready low
module linear_probe_hash_set (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  lphs_pkg::req_type          req_payload,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output lphs_pkg::rsp_type          rsp_payload,
   input  logic                       csr_wr_en,
   input  logic [lphs_pkg::CFG_W-1:0] csr_wr_data
);
   import lphs_pkg::*;

   logic [CFG_W-1:0] table_log2_ff, table_log2_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_payload_ff, rsp_payload_in;
   logic             out_busy;
   logic             done;
   rsp_type          result;
   mem_req_type      mem_req;
   logic [KEY_W-1:0] rd_data;

   assign out_busy = rsp_valid_ff && !rsp_ready;

   always_comb begin
      table_log2_in  = csr_wr_en ? csr_wr_data : table_log2_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      if (done) begin
         rsp_valid_in   = 1'b1;
         rsp_payload_in = result;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_log2_ff <= CFG_RESET;
         rsp_valid_ff  <= 1'b0;
      end else begin
         table_log2_ff <= table_log2_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   lphs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .table_log2  (table_log2_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .out_busy    (out_busy),
      .done        (done),
      .result      (result),
      .mem_req     (mem_req),
      .rd_data     (rd_data)
   );

   lphs_slot_ram u_slot_ram (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

endmodule
